/* rtl/core/tsfd_pkg.sv */
`timescale 1ns / 1ps

package tsfd_pkg;

  // Number of samples carried by one frame (1 to 256).
  localparam int SAMPLES_PER_FRAME = 200;

  // Queue between the framing front end and the sample back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Result queue at the output of the back end.
  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);

  // Configuration register indexes.
  localparam logic [7:0] REG_REF_TYPE  = 8'd0;
  localparam logic [7:0] REG_ERR_TYPE  = 8'd1;
  localparam logic [7:0] REG_REF_SCALE = 8'd2;
  localparam logic [7:0] REG_ERR_SCALE = 8'd3;

  // Reset values of the configuration registers.
  localparam logic [15:0] REF_TYPE_RESET  = 16'd0;
  localparam logic [15:0] ERR_TYPE_RESET  = 16'd1;
  localparam logic [12:0] REF_SCALE_RESET = 13'd1004;
  localparam logic [12:0] ERR_SCALE_RESET = 13'd1004;

  // Reset values of the per-channel running extremes.
  localparam logic signed [15:0] MIN_RESET = 16'sd32767;
  localparam logic signed [15:0] MAX_RESET = -16'sd32767;

  // Full-scale divisor of the scaled value.
  localparam logic [15:0] SCALE_DIV = 16'd32767;

  typedef struct packed {
    logic [15:0] ref_type_code;
    logic [15:0] err_type_code;
    logic [12:0] ref_gain;
    logic [12:0] err_gain;
  } cfg_regs_t;

  typedef struct packed {
    logic               channel;
    logic [7:0]         sample_index;
    logic signed [15:0] raw_sample;
    logic               frame_last;
  } sample_t;

  typedef struct packed {
    logic               channel;
    logic [7:0]         sample_index;
    logic signed [15:0] raw_sample;
    logic signed [13:0] scaled_value;
    logic signed [15:0] running_min;
    logic signed [15:0] running_max;
    logic               frame_last;
  } result_t;

  // Handshake between the sample queue and the back end.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

/* rtl/core/tsfd_front.sv */
`timescale 1ns / 1ps

module tsfd_front import tsfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [7:0] rx_byte,
  input  cfg_regs_t cfg,
  output logic      sample_push,
  output sample_t   sample
);

  logic [7:0] held_byte;
  logic       held_valid;
  logic       in_payload;
  logic       frame_channel;
  logic [7:0] sample_counter;
  logic       low_half_pending;

  logic [15:0] word;
  logic        ref_hit;
  logic        err_hit;
  logic        last;

  assign word    = {rx_byte, held_byte};
  assign ref_hit = (word == cfg.ref_type_code);
  assign err_hit = (word == cfg.err_type_code);
  assign last    = ({1'b0, sample_counter} + 9'd1) >= 9'(SAMPLES_PER_FRAME);

  // A sample is complete when its high byte arrives.
  assign sample_push         = accept && in_payload && low_half_pending;
  assign sample.channel      = frame_channel;
  assign sample.sample_index = sample_counter;
  assign sample.raw_sample   = signed'(word);
  assign sample.frame_last   = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte        <= '0;
      held_valid       <= 1'b0;
      in_payload       <= 1'b0;
      frame_channel    <= 1'b0;
      sample_counter   <= '0;
      low_half_pending <= 1'b0;
    end else if (accept) begin
      if (!in_payload) begin
        if (!held_valid) begin
          held_byte  <= rx_byte;
          held_valid <= 1'b1;
        end else if (ref_hit || err_hit) begin
          // The reference code wins when both codes are equal.
          frame_channel    <= !ref_hit;
          in_payload       <= 1'b1;
          held_valid       <= 1'b0;
          sample_counter   <= '0;
          low_half_pending <= 1'b0;
        end else begin
          held_byte <= rx_byte;
        end
      end else if (!low_half_pending) begin
        held_byte        <= rx_byte;
        low_half_pending <= 1'b1;
      end else begin
        low_half_pending <= 1'b0;
        if (last) begin
          in_payload     <= 1'b0;
          held_valid     <= 1'b0;
          sample_counter <= '0;
        end else begin
          sample_counter <= sample_counter + 8'd1;
        end
      end
    end
  end

endmodule

/* rtl/core/tsfd_queue.sv */
`timescale 1ns / 1ps

module tsfd_queue import tsfd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sample_t       item_in,
  input  logic          pop,
  output sample_t       item_out,
  output queue_status_t status
);

  sample_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign status.empty = (count == '0);
  assign status.full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign item_out     = entries[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/tsfd_back.sv */
`timescale 1ns / 1ps

module tsfd_back import tsfd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_regs_t     cfg,
  input  queue_status_t q_status,
  input  sample_t       q_item,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output result_t       result
);

  // Stage 1: product and running extremes.
  logic               v1;
  sample_t            item1;
  logic signed [29:0] prod1;
  logic signed [15:0] min1;
  logic signed [15:0] max1;

  // Stage 2: magnitude split for the division by 32767.
  logic               v2;
  sample_t            item2;
  logic signed [15:0] min2;
  logic signed [15:0] max2;
  logic               neg2;
  logic [12:0]        quo2;
  logic [15:0]        rem2;

  logic signed [15:0] ch_min [2];
  logic signed [15:0] ch_max [2];

  result_t           outq [OUT_DEPTH];
  logic [OPTR_W-1:0] owptr;
  logic [OPTR_W-1:0] orptr;
  logic [OPTR_W:0]   ocount;
  logic [OPTR_W+1:0] occupancy;
  logic              out_pop;

  logic signed [15:0] cur_min;
  logic signed [15:0] cur_max;
  logic signed [15:0] new_min;
  logic signed [15:0] new_max;
  logic signed [13:0] scale;
  logic [29:0]        mag;
  logic [13:0]        qmag;
  result_t            res_in;

  // Take a sample only when the result queue has room for it and for
  // everything still in the pipeline.
  assign occupancy = (OPTR_W+2)'(ocount) + (OPTR_W+2)'(v1) + (OPTR_W+2)'(v2);
  assign q_pop     = !q_status.empty && (occupancy < (OPTR_W+2)'(OUT_DEPTH));

  assign cur_min = ch_min[q_item.channel];
  assign cur_max = ch_max[q_item.channel];
  assign new_min = (q_item.raw_sample < cur_min) ? q_item.raw_sample : cur_min;
  assign new_max = (q_item.raw_sample > cur_max) ? q_item.raw_sample : cur_max;
  assign scale   = signed'({1'b0, q_item.channel ? cfg.err_gain : cfg.ref_gain});

  assign mag = prod1[29] ? 30'(-prod1) : 30'(prod1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      ch_min[0] <= MIN_RESET;
      ch_min[1] <= MIN_RESET;
      ch_max[0] <= MAX_RESET;
      ch_max[1] <= MAX_RESET;
    end else begin
      v1 <= q_pop;
      v2 <= v1;
      if (q_pop) begin
        ch_min[q_item.channel] <= new_min;
        ch_max[q_item.channel] <= new_max;
      end
    end
  end

  always_ff @(posedge clk) begin
    item1 <= q_item;
    prod1 <= 30'(q_item.raw_sample) * 30'(scale);
    min1  <= new_min;
    max1  <= new_max;
    item2 <= item1;
    min2  <= min1;
    max2  <= max1;
    neg2  <= prod1[29];
    // With q = m >> 15 the remainder m - 32767*q is (m mod 32768) + q,
    // which stays below twice the divisor.
    quo2  <= mag[27:15];
    rem2  <= {1'b0, mag[14:0]} + {3'b000, mag[27:15]};
  end

  assign qmag = {1'b0, quo2} + ((rem2 >= SCALE_DIV) ? 14'd1 : 14'd0);

  always_comb begin
    res_in.channel      = item2.channel;
    res_in.sample_index = item2.sample_index;
    res_in.raw_sample   = item2.raw_sample;
    res_in.scaled_value = neg2 ? -signed'(qmag) : signed'(qmag);
    res_in.running_min  = min2;
    res_in.running_max  = max2;
    res_in.frame_last   = item2.frame_last;
  end

  assign empty   = (ocount == '0);
  assign out_pop = pop && !empty;
  assign result  = outq[orptr];

  always_ff @(posedge clk) begin
    if (v2) begin
      outq[owptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= '0;
      orptr  <= '0;
      ocount <= '0;
    end else begin
      if (v2) begin
        owptr <= owptr + 1'b1;
      end
      if (out_pop) begin
        orptr <= orptr + 1'b1;
      end
      if (v2 && !out_pop) begin
        ocount <= ocount + 1'b1;
      end else if (out_pop && !v2) begin
        ocount <= ocount - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/typed_sample_frame_deframer_unit.sv */
`timescale 1ns / 1ps

// Typed sample frame deframer.
// Input channel: one received byte per transfer on rx_byte, taken on a clock edge
// with push high and full low. Bytes may arrive in every cycle. The front end hunts
// for a little-endian type word equal to the reference or error type code, sliding
// by one byte on a mismatch, then gathers SAMPLES_PER_FRAME signed 16-bit samples.
// Result channel: each completed sample gives one result transfer, shown while empty
// is low and taken on a clock edge with pop high. A result carries the channel, the
// sample index, the raw sample, trunc(sample*scale/32767), the running minimum and
// maximum of that channel since reset, and a last-sample flag.
// Path: the sample passes a four-entry queue, a multiply stage and a division stage,
// then a four-entry result queue. Throughput is one byte per cycle while full is low,
// and each result takes two of those bytes; the front end never waits on the arithmetic.
// When the receiver stalls, the result queue fills, the back end stops draining the
// sample queue, and full rises once that queue is full as well.
// Configuration: a write transfer on cfg_valid/cfg_ready (ready is always high) sets
// the register chosen by cfg_index; unknown indexes are ignored.
// Reset (rst, synchronous) empties both queues, restarts the hunt and restores the
// register defaults and the running extremes.

module typed_sample_frame_deframer_unit import tsfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic               push,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic               channel,
  output logic [7:0]         sample_index,
  output logic signed [15:0] raw_sample,
  output logic signed [13:0] scaled_value,
  output logic signed [15:0] running_min,
  output logic signed [15:0] running_max,
  output logic               frame_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_regs_t     cfg;
  queue_status_t q_status;
  logic          accept;
  logic          sample_push;
  sample_t       sample;
  sample_t       q_item;
  logic          q_pop;
  result_t       result;

  // The register port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_type_code <= REF_TYPE_RESET;
      cfg.err_type_code <= ERR_TYPE_RESET;
      cfg.ref_gain      <= REF_SCALE_RESET;
      cfg.err_gain      <= ERR_SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REF_TYPE:  cfg.ref_type_code <= cfg_data;
        REG_ERR_TYPE:  cfg.err_type_code <= cfg_data;
        REG_REF_SCALE: cfg.ref_gain      <= cfg_data[12:0];
        REG_ERR_SCALE: cfg.err_gain      <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // A byte is taken whenever the sample queue has room, even if this
  // byte completes no sample.
  assign full   = q_status.full;
  assign accept = push && !full;

  tsfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (rx_byte),
    .cfg         (cfg),
    .sample_push (sample_push),
    .sample      (sample)
  );

  tsfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (sample_push),
    .item_in  (sample),
    .pop      (q_pop),
    .item_out (q_item),
    .status   (q_status)
  );

  tsfd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_status (q_status),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .result   (result)
  );

  assign channel      = result.channel;
  assign sample_index = result.sample_index;
  assign raw_sample   = result.raw_sample;
  assign scaled_value = result.scaled_value;
  assign running_min  = result.running_min;
  assign running_max  = result.running_max;
  assign frame_last   = result.frame_last;

  // The running minimum always includes the sample it travels with.
  a_min_covers_sample: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (running_min <= raw_sample))
    else $error("running minimum above its own sample");

  // The maximum covers its sample, except that it may rest at its reset
  // value while only the most negative sample has been seen.
  a_max_covers_sample: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((running_max >= raw_sample) || (raw_sample == 16'sh8000)))
    else $error("running maximum below its own sample");

  // The frame ends exactly at the configured sample count.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (frame_last == (sample_index == 8'(SAMPLES_PER_FRAME - 1))))
    else $error("last flag and sample index disagree");

  // A sample that is not negative never gets a negative scaled value.
  a_scaled_sign: assert property (@(posedge clk) disable iff (rst)
    (!empty && (raw_sample >= 16'sd0)) |-> (scaled_value >= 14'sd0))
    else $error("scaled value sign flipped");

endmodule

/* tb/sv/tsfd_sample_checker.sv */
`timescale 1ns / 1ps

// Watches the byte, register and result channels of the deframer. It keeps its own
// copy of the framing state, the registers and the running extremes, builds the
// expected sample for every accepted high byte, and compares each result transfer
// with the oldest one waiting.
module tsfd_sample_checker import tsfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rx_byte,
  input  logic               push,
  input  logic               full,
  input  logic               empty,
  input  logic               pop,
  input  logic               channel,
  input  logic [7:0]         sample_index,
  input  logic signed [15:0] raw_sample,
  input  logic signed [13:0] scaled_value,
  input  logic signed [15:0] running_min,
  input  logic signed [15:0] running_max,
  input  logic               frame_last,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 samples_checked
);

  cfg_regs_t          regs;
  logic [7:0]         carry_byte;
  logic               carry_valid;
  logic               in_frame;
  logic               frame_ch;
  logic               high_next;
  int                 frame_pos;
  logic signed [15:0] ch_min [2];
  logic signed [15:0] ch_max [2];
  result_t            pending_samples [$];
  int                 mismatch_total;
  int                 samples_seen;

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatch_total++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // One received byte: hunt for a type word, or assemble a sample and predict it.
  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0]        word;
    logic signed [15:0] s;
    int                 scaled;
    result_t            r;
    if (!in_frame) begin
      if (!carry_valid) begin
        carry_byte  = b;
        carry_valid = 1'b1;
      end else begin
        word = {b, carry_byte};
        if (word == regs.ref_type_code || word == regs.err_type_code) begin
          // The reference code wins when both codes are equal.
          frame_ch    = (word == regs.ref_type_code) ? 1'b0 : 1'b1;
          in_frame    = 1'b1;
          carry_valid = 1'b0;
          frame_pos   = 0;
          high_next   = 1'b0;
        end else begin
          carry_byte = b;
        end
      end
    end else if (!high_next) begin
      carry_byte = b;
      high_next  = 1'b1;
    end else begin
      high_next = 1'b0;
      s = {b, carry_byte};
      scaled = (int'(s) * int'(frame_ch ? regs.err_gain : regs.ref_gain))
               / int'(SCALE_DIV);
      if (s > ch_max[frame_ch]) ch_max[frame_ch] = s;
      if (s < ch_min[frame_ch]) ch_min[frame_ch] = s;
      r.channel      = frame_ch;
      r.sample_index = frame_pos[7:0];
      r.raw_sample   = s;
      r.scaled_value = scaled[13:0];
      r.running_min  = ch_min[frame_ch];
      r.running_max  = ch_max[frame_ch];
      r.frame_last   = (frame_pos + 1 >= SAMPLES_PER_FRAME);
      pending_samples.push_back(r);
      if (r.frame_last) begin
        in_frame    = 1'b0;
        carry_valid = 1'b0;
        frame_pos   = 0;
      end else begin
        frame_pos = (frame_pos + 1) & 255;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      regs.ref_type_code = REF_TYPE_RESET;
      regs.err_type_code = ERR_TYPE_RESET;
      regs.ref_gain      = REF_SCALE_RESET;
      regs.err_gain      = ERR_SCALE_RESET;
      carry_byte  = '0;
      carry_valid = 1'b0;
      in_frame    = 1'b0;
      frame_ch    = 1'b0;
      high_next   = 1'b0;
      frame_pos   = 0;
      ch_min[0]   = MIN_RESET;
      ch_min[1]   = MIN_RESET;
      ch_max[0]   = MAX_RESET;
      ch_max[1]   = MAX_RESET;
      pending_samples.delete();
    end else begin
      // Results are checked before this edge's byte is predicted, so a stray result
      // can never be matched against a sample that was only just accepted.
      if (pop && !empty) begin
        if (pending_samples.size() == 0) begin
          mismatch_total++;
          $display("%0t: unexpected result, expected none, actual index %0d raw %0d",
                   $time, sample_index, raw_sample);
        end else begin
          want = pending_samples.pop_front();
          samples_seen++;
          if (channel !== want.channel)
            note_mismatch("channel", want.channel, channel);
          if (sample_index !== want.sample_index)
            note_mismatch("sample_index", want.sample_index, sample_index);
          if (raw_sample !== want.raw_sample)
            note_mismatch("raw_sample", want.raw_sample, raw_sample);
          if (scaled_value !== want.scaled_value)
            note_mismatch("scaled_value", want.scaled_value, scaled_value);
          if (running_min !== want.running_min)
            note_mismatch("running_min", want.running_min, running_min);
          if (running_max !== want.running_max)
            note_mismatch("running_max", want.running_max, running_max);
          if (frame_last !== want.frame_last)
            note_mismatch("frame_last", want.frame_last, frame_last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REF_TYPE:  regs.ref_type_code = cfg_data;
          REG_ERR_TYPE:  regs.err_type_code = cfg_data;
          REG_REF_SCALE: regs.ref_gain      = cfg_data[12:0];
          REG_ERR_SCALE: regs.err_gain      = cfg_data[12:0];
          default: ;
        endcase
      end
      if (push && !full) deframe_byte(rx_byte);
    end
    mismatches      <= mismatch_total;
    outstanding     <= pending_samples.size();
    samples_checked <= samples_seen;
  end

endmodule

/* tb/sv/tb_typed_sample_frame_deframer_unit.sv */
`timescale 1ns / 1ps

module tb_typed_sample_frame_deframer_unit import tsfd_pkg::*; ();

  // A register index that decodes to nothing; writes to it must be ignored.
  localparam logic [7:0] REG_SPARE = 8'd200;

  // Cycles allowed after the last expected result before registers change or the
  // run ends. A sample passes both queues and the multiply and division stages.
  localparam int SETTLE_CYCLES = 12;

  logic               clk;
  logic               rst       = 1'b1;
  logic [7:0]         rx_byte   = '0;
  logic               push      = 1'b0;
  logic               pop       = 1'b0;
  logic               cfg_valid = 1'b0;
  logic [7:0]         cfg_index = '0;
  logic [15:0]        cfg_data  = '0;
  logic               full;
  logic               empty;
  logic               cfg_ready;
  logic               channel;
  logic [7:0]         sample_index;
  logic signed [15:0] raw_sample;
  logic signed [13:0] scaled_value;
  logic signed [15:0] running_min;
  logic signed [15:0] running_max;
  logic               frame_last;

  int mismatches;
  int outstanding;
  int samples_checked;

  // Chance in percent that the byte source idles before a byte, and that the
  // result sink holds pop low in a given cycle. Each phase after the first sets both.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int bytes_sent    = 0;

  typed_sample_frame_deframer_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .channel      (channel),
    .sample_index (sample_index),
    .raw_sample   (raw_sample),
    .scaled_value (scaled_value),
    .running_min  (running_min),
    .running_max  (running_max),
    .frame_last   (frame_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  tsfd_sample_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .rx_byte         (rx_byte),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .channel         (channel),
    .sample_index    (sample_index),
    .raw_sample      (raw_sample),
    .scaled_value    (scaled_value),
    .running_min     (running_min),
    .running_max     (running_max),
    .frame_last      (frame_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .samples_checked (samples_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The result sink decides afresh every cycle whether to take a result, so that
  // stalls land on every stage of the pipeline and on both queues.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // One byte transfer. Idle cycles come first, then push stays high until the block
  // takes the byte. Push is not lowered on return: the next call either idles or
  // presents its own byte, so push gets only one assignment per time step.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  // Type words and samples are both sent low byte first.
  task automatic push_word(input logic [15:0] w);
    push_byte(w[7:0]);
    push_byte(w[15:8]);
  endtask

  // Samples lean on the extremes and on values near zero, where the truncation of
  // the scaled value and the running extremes are most likely to go wrong.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4:       return 16'h0001;
      5:       return 16'(16'sd0 - $urandom_range(40));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic push_samples(input int count);
    repeat (count) push_word(pick_sample());
  endtask

  // Random bytes between frames; the hunt has to slide through them.
  task automatic push_noise(input int count);
    repeat (count) push_byte(8'($urandom_range(255)));
  endtask

  // Register writes are back to back, so valid is lowered only after the last one.
  // The spare index is written first with a value that would break framing if the
  // block decoded it as a type code.
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input logic [15:0] ref_code, input logic [15:0] err_code,
                           input logic [15:0] ref_sc, input logic [15:0] err_sc);
    write_reg(REG_SPARE, 16'hBEEF);
    write_reg(REG_REF_TYPE, ref_code);
    write_reg(REG_ERR_TYPE, err_code);
    write_reg(REG_REF_SCALE, ref_sc);
    write_reg(REG_ERR_SCALE, err_sc);
    cfg_valid <= 1'b0;
  endtask

  // Hold the byte source until every predicted sample has been taken, then give the
  // block time to finish any byte that produces no result.
  task automatic settle();
    push <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [15:0] rand_ref;
    logic [15:0] rand_err;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening with the reset registers (reference code 0, error code 1)
    // and no idling. The first two words do not match, so the hunt slides twice
    // before 00 00 starts a reference frame.
    push_byte(8'h12);
    push_byte(8'h34);
    push_byte(8'h00);
    push_byte(8'h00);
    // Two samples of -32768 first: the minimum drops below its reset value while
    // the maximum still rests at -32767. Then the positive full-scale end, zero, -1, +1
    // and two values that put ones in opposite bytes.
    push_word(16'h8000);
    push_word(16'h8000);
    push_word(16'h7FFF);
    push_word(16'h0000);
    push_word(16'hFFFF);
    push_word(16'h0001);
    push_word(16'h00FF);
    push_word(16'hFF00);
    push_samples(SAMPLES_PER_FRAME - 8);
    // After the last sample the window is empty, so the error code follows at once.
    // This error frame is left half done across the next register change.
    push_word(ERR_TYPE_RESET);
    push_samples(SAMPLES_PER_FRAME / 2);
    settle();

    // Sender idling. Type codes at both ends of their range, the reference scale
    // written with all ones so that only its low 13 bits stick, and the error scale
    // at its maximum. The open error frame finishes under the new scale.
    send_idle_pct = 57;
    stall_pct     = 0;
    load_regs(16'hFFFF, 16'h0000, 16'hFFFF, 16'h1FFF);
    push_samples(SAMPLES_PER_FRAME - SAMPLES_PER_FRAME / 2);
    push_noise($urandom_range(6));
    push_word(16'h0000);
    push_samples(SAMPLES_PER_FRAME);
    push_noise($urandom_range(6));
    push_word(16'hFFFF);
    push_samples(8);
    settle();

    // Receiver stalling, so both queues fill and full rises. Both codes are equal,
    // which must start a reference frame, and both scales are zero. The short
    // reference frame from the last phase runs on under the new codes first.
    send_idle_pct = 0;
    stall_pct     = 57;
    load_regs(16'hA55A, 16'hA55A, 16'h0000, 16'h0000);
    push_samples(SAMPLES_PER_FRAME - 8);
    push_noise($urandom_range(6));
    push_word(16'hA55A);
    push_samples(SAMPLES_PER_FRAME);
    settle();

    // Both sides idle now and then, with random codes and scales, and one short
    // frame on a randomly chosen channel.
    send_idle_pct = 23;
    stall_pct     = 23;
    rand_ref = 16'($urandom_range(65535));
    rand_err = rand_ref ^ 16'h8421;
    load_regs(rand_ref, rand_err, 16'($urandom_range(8191)), 16'($urandom_range(8191)));
    push_noise($urandom_range(1, 8));
    push_word($urandom_range(1) ? rand_err : rand_ref);
    push_samples(SAMPLES_PER_FRAME / 8);
    settle();

    $display("Covered %0d byte transfers and %0d sample results on both channels,",
             bytes_sent, samples_checked);
    $display("four register settings, code and scale extremes, and all idle modes.");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // The timeout lies far beyond the length of a correct run.
  initial begin
    #4ms;
    $display("Timeout with %0d samples still expected", outstanding);
    $display("Regression FAIL");
    $finish;
  end

endmodule
